@@ rtl/core/rmsn_pkg.sv @@
`timescale 1ns / 1ps

package rmsn_pkg;

	// register and gain formats
	localparam int TARGET_W     = 15;
	localparam int TARGET_RESET = 3277;
	localparam int GAIN_W       = 24;
	localparam int GAIN_FRAC    = 16;

	// sequencer states
	typedef enum logic [9:0] {
		S_IDLE = 10'b00_0000_0001,
		S_SQ   = 10'b00_0000_0010,
		S_ACC  = 10'b00_0000_0100,
		S_MEAN = 10'b00_0000_1000,
		S_ROOT = 10'b00_0001_0000,
		S_GAIN = 10'b00_0010_0000,
		S_RD   = 10'b00_0100_0000,
		S_MUL  = 10'b00_1000_0000,
		S_FMT  = 10'b01_0000_0000,
		S_OUT  = 10'b10_0000_0000
	} state_t;

endpackage

@@ rtl/core/rmsn_div.sv @@
`timescale 1ns / 1ps

module rmsn_div #(
	parameter int DW  = 37,
	parameter int DVW = 17
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [DW-1:0]  dividend,
	input  logic [DVW-1:0] divisor,
	output logic           done,
	output logic [DW-1:0]  quotient
);

	localparam int CNT_W = $clog2(DW + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DVW-1:0]   rem_q;
	logic [DW-1:0]    quo_q;
	logic [DVW-1:0]   dvs_q;
	logic [DVW:0]     trial;
	logic             fits;

	// one quotient bit per cycle, restoring
	assign trial = {rem_q, quo_q[DW-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	// iteration control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// partial remainder and quotient shift
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= DVW'(trial - {1'b0, dvs_q});
			end else begin
				rem_q <= trial[DVW-1:0];
			end
			quo_q <= {quo_q[DW-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

@@ rtl/core/rmsn_sqrt.sv @@
`timescale 1ns / 1ps

module rmsn_sqrt #(
	parameter int RW = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [2*RW-1:0] radicand,
	output logic            done,
	output logic [RW-1:0]   root
);

	localparam int CNT_W = $clog2(RW + 1);
	localparam int REM_W = RW + 2;

	logic             busy_q;
	logic             fin_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [2*RW-1:0]  rad_q;
	logic [REM_W-1:0] rem_q;
	logic [RW-1:0]    root_q;
	logic [REM_W-1:0] shifted;
	logic [REM_W-1:0] trial;
	logic             fits;

	// one root digit per cycle from the top pair of radicand bits
	assign shifted = {rem_q[REM_W-3:0], rad_q[2*RW-1 -: 2]};
	assign trial   = {root_q, 2'b01};
	assign fits    = shifted >= trial;

	// iteration control, then a rounding step after the last digit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			fin_q  <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(RW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end
			end else if (fin_q) begin
				done_q <= 1'b1;
			end
		end
	end

	// remainder and root, rounded to nearest at the end
	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= {rad_q[2*RW-3:0], 2'b00};
			rem_q  <= fits ? REM_W'(shifted - trial) : shifted;
			root_q <= {root_q[RW-2:0], fits};
		end else if (fin_q) begin
			root_q <= root_q + RW'(rem_q > REM_W'(root_q));
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

@@ rtl/core/rms_frame_normalizer_top.sv @@
`timescale 1ns / 1ps

// Frame RMS normalizer. Samples enter on s_axis (tlast closes the frame; a full
// store of MAX_SAMPLES also closes it) and each passes three steps: accept,
// square, accumulate. On close, one shared restoring divider works out the mean
// square, an iterative square root follows, and the same divider then forms the
// gain, Q8.16 saturated. The frame is then replayed from the sample store one
// output at a time, each through read, multiply, format and output states, the
// last held by any m_axis_tready stall. Each output is the stored sample times
// the gain, rounded half away from zero and saturated. A frame whose RMS rounds
// to zero is replayed unchanged with tuser set. The input is not ready while a
// frame is being worked out or replayed. The user writes target_level through
// cfg_we and cfg_data only while the block is idle; the block does not enforce
// this. target_level resets to 3277 (about 0.1 in unsigned Q0.15).
module rms_frame_normalizer_top #(
	parameter  int MAX_SAMPLES = 64,
	parameter  int SAMPLE_BITS = 16,
	localparam int TD_W        = ((SAMPLE_BITS + 7) / 8) * 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [rmsn_pkg::TARGET_W-1:0] cfg_data,       // target_level
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [TD_W-1:0]               s_axis_tdata,   // sample_in
	input  logic                          s_axis_tlast,   // frame_end
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [TD_W-1:0]               m_axis_tdata,   // sample_out
	output logic                          m_axis_tlast,   // run_last
	output logic                          m_axis_tuser    // bypassed
);

	localparam int SB      = SAMPLE_BITS;
	localparam int GW      = rmsn_pkg::GAIN_W;
	localparam int AW      = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
	localparam int CW      = $clog2(MAX_SAMPLES + 1);
	localparam int SQ_W    = 2 * SB;
	localparam int SUM_W   = 2 * SB + 5;
	localparam int GN_W    = rmsn_pkg::TARGET_W + SB + 1;
	localparam int DIV_MIN = (SUM_W > GN_W) ? SUM_W : GN_W;
	localparam int DIV_W   = (DIV_MIN > GW) ? DIV_MIN : GW + 1;
	localparam int DVS_W   = SB + 1;
	localparam int PW      = SB + GW;
	localparam int RND_W   = PW - rmsn_pkg::GAIN_FRAC + 1;

	rmsn_pkg::state_t state_q;

	logic                          go_q;
	logic [rmsn_pkg::TARGET_W-1:0] target_q;
	logic [CW-1:0]                 fill_q;
	logic [CW-1:0]                 idx_q;
	logic [SUM_W-1:0]              sum_q;
	logic                          m_valid_q;

	logic [SB-1:0]                 mem_q [MAX_SAMPLES];
	logic signed [SB-1:0]          smp_q;
	logic                          close_q;
	logic [SQ_W-1:0]               sq_s1;
	logic [SQ_W-1:0]               mean_q;
	logic [SB-1:0]                 rms_q;
	logic [GW-1:0]                 gain_q;
	logic                          bypass_q;
	logic [SB-1:0]                 rd_q;
	logic [PW-1:0]                 prod_s1;
	logic                          neg_s1;
	logic [SB-1:0]                 m_data_q;
	logic                          m_last_q;

	logic                          in_req;
	logic                          closing;
	logic signed [SQ_W-1:0]        sq_full;
	logic [GN_W-1:0]               gain_num;
	logic                          div_start;
	logic [DIV_W-1:0]              div_dividend;
	logic [DVS_W-1:0]              div_divisor;
	logic                          div_done;
	logic [DIV_W-1:0]              div_quo;
	logic                          sqrt_start;
	logic                          sqrt_done;
	logic [SB-1:0]                 sqrt_root;
	logic                          rd_neg;
	logic [SB-1:0]                 rd_mag;
	logic [PW:0]                   rnd_sum;
	logic [RND_W-1:0]              rnd;
	logic [SB-1:0]                 scaled;

	assign in_req  = s_axis_tvalid && (state_q == rmsn_pkg::S_IDLE);
	assign closing = s_axis_tlast || (fill_q == CW'(MAX_SAMPLES - 1));
	assign sq_full = smp_q * smp_q;

	// gain = floor((target * 2^(SB+1) + rms) / (2 * rms)), i.e. rounded quotient
	assign gain_num = {target_q, (SB + 1)'(0)} | GN_W'(rms_q);

	// operand select for the shared divider
	always_comb begin
		if (state_q == rmsn_pkg::S_GAIN) begin
			div_dividend = DIV_W'(gain_num);
			div_divisor  = {rms_q, 1'b0};
		end else begin
			div_dividend = DIV_W'(sum_q);
			div_divisor  = DVS_W'(fill_q);
		end
	end

	assign div_start  = go_q && ((state_q == rmsn_pkg::S_MEAN) ||
		(state_q == rmsn_pkg::S_GAIN));
	assign sqrt_start = go_q && (state_q == rmsn_pkg::S_ROOT);

	rmsn_div #(
		.DW  (DIV_W),
		.DVW (DVS_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quo)
	);

	rmsn_sqrt #(
		.RW (SB)
	) u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sqrt_start),
		.radicand (mean_q),
		.done     (sqrt_done),
		.root     (sqrt_root)
	);

	// magnitude of the stored sample
	assign rd_neg = rd_q[SB-1];
	assign rd_mag = rd_neg ? (~rd_q + SB'(1)) : rd_q;

	// round half away from zero, then saturate
	assign rnd_sum = {1'b0, prod_s1} + (PW + 1)'(1 << (rmsn_pkg::GAIN_FRAC - 1));
	assign rnd     = rnd_sum[PW:rmsn_pkg::GAIN_FRAC];

	always_comb begin
		if (!neg_s1) begin
			if (rnd > RND_W'((1 << (SB - 1)) - 1)) begin
				scaled = {1'b0, {(SB - 1){1'b1}}};
			end else begin
				scaled = rnd[SB-1:0];
			end
		end else begin
			if (rnd > RND_W'(1 << (SB - 1))) begin
				scaled = {1'b1, {(SB - 1){1'b0}}};
			end else begin
				scaled = ~rnd[SB-1:0] + SB'(1);
			end
		end
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= rmsn_pkg::TARGET_W'(rmsn_pkg::TARGET_RESET);
		end else if (cfg_we) begin
			target_q <= cfg_data;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= rmsn_pkg::S_IDLE;
			go_q      <= 1'b0;
			fill_q    <= '0;
			idx_q     <= '0;
			sum_q     <= '0;
			m_valid_q <= 1'b0;
		end else begin
			go_q <= 1'b0;
			case (state_q)
				rmsn_pkg::S_IDLE: begin
					if (in_req) begin
						fill_q  <= fill_q + CW'(1);
						state_q <= rmsn_pkg::S_SQ;
					end
				end
				rmsn_pkg::S_SQ: begin
					state_q <= rmsn_pkg::S_ACC;
				end
				rmsn_pkg::S_ACC: begin
					sum_q <= sum_q + SUM_W'(sq_s1);
					if (close_q) begin
						go_q    <= 1'b1;
						idx_q   <= '0;
						state_q <= rmsn_pkg::S_MEAN;
					end else begin
						state_q <= rmsn_pkg::S_IDLE;
					end
				end
				rmsn_pkg::S_MEAN: begin
					if (div_done) begin
						go_q    <= 1'b1;
						state_q <= rmsn_pkg::S_ROOT;
					end
				end
				rmsn_pkg::S_ROOT: begin
					if (sqrt_done) begin
						if (sqrt_root == '0) begin
							state_q <= rmsn_pkg::S_RD;
						end else begin
							go_q    <= 1'b1;
							state_q <= rmsn_pkg::S_GAIN;
						end
					end
				end
				rmsn_pkg::S_GAIN: begin
					if (div_done) begin
						state_q <= rmsn_pkg::S_RD;
					end
				end
				rmsn_pkg::S_RD: begin
					state_q <= rmsn_pkg::S_MUL;
				end
				rmsn_pkg::S_MUL: begin
					state_q <= rmsn_pkg::S_FMT;
				end
				rmsn_pkg::S_FMT: begin
					m_valid_q <= 1'b1;
					state_q   <= rmsn_pkg::S_OUT;
				end
				rmsn_pkg::S_OUT: begin
					if (m_axis_tready) begin
						m_valid_q <= 1'b0;
						if (m_last_q) begin
							fill_q  <= '0;
							sum_q   <= '0;
							state_q <= rmsn_pkg::S_IDLE;
						end else begin
							idx_q   <= idx_q + CW'(1);
							state_q <= rmsn_pkg::S_RD;
						end
					end
				end
				default: begin
					state_q <= rmsn_pkg::S_IDLE;
				end
			endcase
		end
	end

	// sample store
	always_ff @(posedge clk) begin
		if (in_req) begin
			mem_q[fill_q[AW-1:0]] <= s_axis_tdata[SB-1:0];
		end
		if (state_q == rmsn_pkg::S_RD) begin
			rd_q <= mem_q[idx_q[AW-1:0]];
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (in_req) begin
			smp_q   <= signed'(s_axis_tdata[SB-1:0]);
			close_q <= closing;
		end
		if (state_q == rmsn_pkg::S_SQ) begin
			sq_s1 <= unsigned'(sq_full);
		end
		if ((state_q == rmsn_pkg::S_MEAN) && div_done) begin
			mean_q <= SQ_W'(div_quo);
		end
		if ((state_q == rmsn_pkg::S_ROOT) && sqrt_done) begin
			rms_q    <= sqrt_root;
			bypass_q <= (sqrt_root == '0);
		end
		if ((state_q == rmsn_pkg::S_GAIN) && div_done) begin
			if (|div_quo[DIV_W-1:GW]) begin
				gain_q <= '1;
			end else begin
				gain_q <= div_quo[GW-1:0];
			end
		end
		if (state_q == rmsn_pkg::S_MUL) begin
			prod_s1 <= PW'(rd_mag) * PW'(gain_q);
			neg_s1  <= rd_neg;
		end
		if (state_q == rmsn_pkg::S_FMT) begin
			m_data_q <= bypass_q ? rd_q : scaled;
			m_last_q <= (idx_q + CW'(1)) == fill_q;
		end
	end

	assign s_axis_tready = (state_q == rmsn_pkg::S_IDLE);
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = TD_W'(m_data_q);
	assign m_axis_tlast  = m_last_q;
	assign m_axis_tuser  = bypass_q;

endmodule

@@ rtl/core/rmsn_checker.sv @@
`timescale 1ns / 1ps

module rmsn_checker #(
	parameter int TD_W = 16
) (
	input logic            clk,
	input logic            arst_n,
	input logic            s_axis_tvalid,
	input logic            s_axis_tready,
	input logic            m_axis_tvalid,
	input logic            m_axis_tready,
	input logic [TD_W-1:0] m_axis_tdata,
	input logic            m_axis_tlast,
	input logic            m_axis_tuser
);

	// a stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) &&
		$stable(m_axis_tlast) && $stable(m_axis_tuser))
	else $error("stalled result changed");

	// no input taken while a result is offered
	assert property (@(posedge clk) disable iff (!arst_n)
		!(s_axis_tready && m_axis_tvalid))
	else $error("input ready during replay");

	// each accepted sample keeps the block busy for its squaring pass
	assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready && !m_axis_tvalid)
	else $error("busy window after input request missing");

	// every delivered result is followed by a fetch gap
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready |=> !m_axis_tvalid)
	else $error("result valid did not drop after request");

endmodule

bind rms_frame_normalizer_top rmsn_checker #(
	.TD_W (TD_W)
) u_rmsn_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast),
	.m_axis_tuser  (m_axis_tuser)
);
